@@ rtl/lpbr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Length-prefixed block receiver package
// Shared codes, widths and record types for the receiver and its channels.
// ----------------------------------------------------------------------------
package lpbr_pkg;

   localparam int unsigned CmdWidth   = 2;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned LenWidth   = 16;
   localparam int unsigned PhaseWidth = 3;

   // Commands carried with each input item.
   localparam logic [CmdWidth-1:0] CMD_BYTE       = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_OPEN       = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_INCOMPLETE = 2'd2;

   // Protocol characters.
   localparam logic [ByteWidth-1:0] CH_HELLO = 8'h48;  // 'H'
   localparam logic [ByteWidth-1:0] CH_READY = 8'h52;  // 'R'
   localparam logic [ByteWidth-1:0] CH_GO    = 8'h47;  // 'G'
   localparam logic [ByteWidth-1:0] CH_START = 8'h53;  // 'S'
   localparam logic [ByteWidth-1:0] CH_DATA  = 8'h44;  // 'D'

   localparam logic [LenWidth-1:0] LIMIT_RESET = 16'd512;

   // Receiver phases.
   localparam logic [PhaseWidth-1:0] PH_HELLO   = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_GO      = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_IDLE    = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_LEN_HI  = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_LEN_LO  = 3'd4;
   localparam logic [PhaseWidth-1:0] PH_PAYLOAD = 3'd5;
   localparam logic [PhaseWidth-1:0] PH_ERROR   = 3'd6;

   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic [LenWidth-1:0]   block_length;
      logic [LenWidth-1:0]   bytes_taken;
      logic                  discarding;
      logic                  incomplete_mark;
   } state_type;

   typedef struct packed {
      logic                 tx_valid;
      logic [ByteWidth-1:0] tx_byte;
      logic                 data_valid;
      logic [ByteWidth-1:0] data_byte;
      logic                 end_of_file;
      logic                 unexpected_byte;
      logic                 length_error;
   } result_type;

endpackage
`default_nettype wire

@@ rtl/lpbr_channels.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Length-prefixed block receiver channels
// Valid/ready channel interfaces for input items, results and the register.
// ----------------------------------------------------------------------------
interface lpbr_req_if;
   import lpbr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CmdWidth-1:0]  command;
   logic [ByteWidth-1:0] rx_byte;
   modport source (output valid, command, rx_byte, input ready);
   modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface lpbr_rsp_if;
   import lpbr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 tx_valid;
   logic [ByteWidth-1:0] tx_byte;
   logic                 data_valid;
   logic [ByteWidth-1:0] data_byte;
   logic                 end_of_file;
   logic                 unexpected_byte;
   logic                 length_error;
   modport source (output valid, tx_valid, tx_byte, data_valid, data_byte,
                   end_of_file, unexpected_byte, length_error, input ready);
   modport sink   (input valid, tx_valid, tx_byte, data_valid, data_byte,
                   end_of_file, unexpected_byte, length_error, output ready);
endinterface

interface lpbr_csr_if;
   import lpbr_pkg::*;
   logic                valid;
   logic                ready;
   logic [LenWidth-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/lpbr_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Length-prefixed block receiver step logic
// Next state and result for one input item.
// ----------------------------------------------------------------------------
module lpbr_step (
   input  lpbr_pkg::state_type                cur_state,
   input  logic [lpbr_pkg::CmdWidth-1:0]      command,
   input  logic [lpbr_pkg::ByteWidth-1:0]     rx_byte,
   input  logic [lpbr_pkg::LenWidth-1:0]      max_block_len,
   output lpbr_pkg::state_type                nxt_state,
   output lpbr_pkg::result_type               result
);
   import lpbr_pkg::*;

   logic [LenWidth-1:0] full_length;
   logic [LenWidth-1:0] taken_inc;

   assign full_length = {cur_state.block_length[LenWidth-1:ByteWidth], rx_byte};
   assign taken_inc   = cur_state.bytes_taken + 16'd1;

   always_comb begin
      nxt_state = cur_state;
      result    = '0;
      if (cur_state.phase != PH_ERROR) begin
         unique case (command)
            CMD_INCOMPLETE: begin
               nxt_state.incomplete_mark = 1'b1;
            end
            CMD_OPEN: begin
               if (cur_state.phase != PH_HELLO && cur_state.phase != PH_GO) begin
                  if (cur_state.incomplete_mark || cur_state.phase == PH_IDLE) begin
                     nxt_state.incomplete_mark = 1'b0;
                     if (cur_state.incomplete_mark) begin
                        nxt_state.discarding = 1'b0;
                     end
                     result.tx_valid        = 1'b1;
                     result.tx_byte         = CH_START;
                     nxt_state.block_length = '0;
                     nxt_state.bytes_taken  = '0;
                     nxt_state.phase        = PH_LEN_HI;
                  end else begin
                     nxt_state.discarding = 1'b1;
                  end
               end
            end
            CMD_BYTE: begin
               unique case (cur_state.phase)
                  PH_HELLO: begin
                     if (rx_byte == CH_HELLO) begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = CH_READY;
                        nxt_state.phase = PH_GO;
                     end
                  end
                  PH_GO: begin
                     if (rx_byte == CH_GO) begin
                        nxt_state.phase = PH_IDLE;
                     end else if (rx_byte != CH_HELLO) begin
                        result.unexpected_byte = 1'b1;
                     end
                  end
                  PH_LEN_HI: begin
                     nxt_state.block_length = {rx_byte, 8'h00};
                     nxt_state.phase        = PH_LEN_LO;
                  end
                  PH_LEN_LO: begin
                     nxt_state.block_length = full_length;
                     nxt_state.bytes_taken  = '0;
                     if (full_length == '0) begin
                        if (cur_state.discarding) begin
                           // The closing header of a dropped file starts the next one.
                           nxt_state.discarding   = 1'b0;
                           result.tx_valid        = 1'b1;
                           result.tx_byte         = CH_START;
                           nxt_state.block_length = '0;
                           nxt_state.phase        = PH_LEN_HI;
                        end else begin
                           result.end_of_file = 1'b1;
                           nxt_state.phase    = PH_IDLE;
                        end
                     end else begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = CH_DATA;
                        nxt_state.phase = (full_length > max_block_len) ? PH_ERROR
                                                                        : PH_PAYLOAD;
                     end
                  end
                  PH_PAYLOAD: begin
                     if (!cur_state.discarding) begin
                        result.data_valid = 1'b1;
                        result.data_byte  = rx_byte;
                     end
                     nxt_state.bytes_taken = taken_inc;
                     if (taken_inc >= cur_state.block_length) begin
                        nxt_state.phase = PH_LEN_HI;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      result.length_error = (nxt_state.phase == PH_ERROR);
   end

endmodule
`default_nettype wire

@@ rtl/length_prefixed_block_receiver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Length-prefixed block receiver
// Byte handshake and length-prefixed block transfer, receive side.
// ----------------------------------------------------------------------------
// The receiver takes one item per clock cycle at full rate: each item is a
// command (received byte, open next file, or mark file incomplete) with its
// byte, and every item yields exactly one result item carrying the reply byte
// to send, a delivered payload byte, the end-of-file and unexpected-byte
// strobes, and the sticky length error. An accepted item waits in the input
// register until the result register is empty or being emptied; the step
// logic then updates the protocol state and fills the result register, which
// offers the result on the result channel. The only limit on rate is the
// single-entry result register: new items keep flowing as long as the result
// side takes one item per cycle. The length limit register is written through
// the csr channel (reset value 512), and it is only to be written while no
// item is in flight. Once a block header exceeds the limit, the block answers
// 'D' and then stays in the error state, flagging length_error on every
// result, until reset.

module length_prefixed_block_receiver (
   input  logic        clock,
   input  logic        reset,
   lpbr_req_if.sink    req_chan,
   lpbr_rsp_if.source  rsp_chan,
   lpbr_csr_if.sink    csr_chan
);
   import lpbr_pkg::*;

   // Input register.
   logic                 in_valid_ff, in_valid_in;
   logic [CmdWidth-1:0]  cmd_ff;
   logic [ByteWidth-1:0] byte_ff;

   // Protocol state and length limit.
   state_type            state_ff, state_in;
   logic [LenWidth-1:0]  max_len_ff;

   // Result register.
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff, out_in;

   logic                 advance;
   logic                 take_item;

   // The item in the input register moves on whenever the result register is
   // empty or is being emptied in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign take_item = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   lpbr_step u_step (
      .cur_state     (state_ff),
      .command       (cmd_ff),
      .rx_byte       (byte_ff),
      .max_block_len (max_len_ff),
      .nxt_state     (state_in),
      .result        (out_in)
   );

   assign in_valid_in  = take_item || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_len_ff   <= LIMIT_RESET;
         state_ff     <= '{phase: PH_HELLO, block_length: '0, bytes_taken: '0,
                           discarding: 1'b0, incomplete_mark: 1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            max_len_ff <= csr_chan.data;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (take_item) begin
         cmd_ff  <= req_chan.command;
         byte_ff <= req_chan.rx_byte;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.tx_valid        = out_ff.tx_valid;
   assign rsp_chan.tx_byte         = out_ff.tx_byte;
   assign rsp_chan.data_valid      = out_ff.data_valid;
   assign rsp_chan.data_byte       = out_ff.data_byte;
   assign rsp_chan.end_of_file     = out_ff.end_of_file;
   assign rsp_chan.unexpected_byte = out_ff.unexpected_byte;
   assign rsp_chan.length_error    = out_ff.length_error;

endmodule
`default_nettype wire
